// ===== src/multi_slot_periodic_tick_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic tick scheduler
// Shared helpers: clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_PERIODIC_TICK_SCHEDULER_MACROS_SVH
`define MULTI_SLOT_PERIODIC_TICK_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MSTS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/msts_pkg.sv =====
// ----------------------------------------------------------------------------
// msts_pkg
// Types and constants of the periodic tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package msts_pkg;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MASK_W   = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_DISARM = 2'd2
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
  } in_beat_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic              running;
    logic              bad_slot;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/msts_if.sv =====
// ----------------------------------------------------------------------------
// msts channel interfaces
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface msts_in_if;
  import msts_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SLOT_W-1:0]   slot;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, output action, output slot, output period, input ready);
  modport sink   (input valid, input action, input slot, input period, output ready);
endinterface

interface msts_out_if;
  import msts_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fire_mask;
  logic              running;
  logic              bad_slot;

  modport source (output valid, output fire_mask, output running, output bad_slot,
                  input ready);
  modport sink   (input valid, input fire_mask, input running, input bad_slot,
                  output ready);
endinterface

`default_nettype wire

// ===== src/multi_slot_periodic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_slot_periodic_tick_scheduler
// Bank of periodic slots advanced by tick beats, armed and disarmed by command.
// ----------------------------------------------------------------------------
// Each command beat (tick, arm, disarm or spare) gives exactly one result beat.
// Beats pass an input register, the combinational slot update logic and a
// result register, and one beat is taken every clock as long as the result
// side keeps up. All slots compare and update in parallel in the update
// logic, so throughput does not depend on the slot count.
`default_nettype none

module multi_slot_periodic_tick_scheduler #(
  parameter int unsigned SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msts_in_if.sink    in_i,
  msts_out_if.source out_o
);
  import msts_pkg::*;

  in_beat_t  in_q;
  logic      in_vld_q;
  out_beat_t out_q;
  logic      out_vld_q;
  out_beat_t res;
  logic      adv;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (!out_vld_q || out_o.ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= '{action: in_i.action, slot: in_i.slot, period: in_i.period};
    end
    if (adv) out_q <= res;
  end

  msts_slot_bank #(
    .SLOTS(SLOTS)
  ) u_bank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .item_i(in_q),
    .res_o (res)
  );

  assign out_o.valid     = out_vld_q;
  assign out_o.fire_mask = out_q.fire_mask;
  assign out_o.running   = out_q.running;
  assign out_o.bad_slot  = out_q.bad_slot;

endmodule

`default_nettype wire

// ===== src/msts_slot_bank.sv =====
// ----------------------------------------------------------------------------
// msts_slot_bank
// Slot state (active, reload, counter), tick enable and the per-beat update.
// ----------------------------------------------------------------------------
`default_nettype none

module msts_slot_bank #(
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  msts_pkg::in_beat_t item_i,
  output msts_pkg::out_beat_t res_o
);
  import msts_pkg::*;

  logic [SLOTS-1:0]    active_q, active_d;
  logic [PERIOD_W-1:0] reload_q [SLOTS];
  logic [PERIOD_W-1:0] reload_d [SLOTS];
  logic [PERIOD_W-1:0] count_q  [SLOTS];
  logic [PERIOD_W-1:0] count_d  [SLOTS];
  logic                tick_en_q, tick_en_d;

  logic [SLOTS-1:0]    hit;
  logic [SLOTS-1:0]    fire;
  logic [MASK_W-1:0]   fire_mask;
  logic                in_range;
  logic                bad;
  logic [PERIOD_W-1:0] new_reload;

  for (genvar i = 0; i < SLOTS; i++) begin : g_hit
    assign hit[i] = (item_i.slot == SLOT_W'(i));
  end

  assign in_range   = ({1'b0, item_i.slot} < (SLOT_W + 1)'(SLOTS));
  assign new_reload = (item_i.period == '0) ? '0 : PERIOD_W'(item_i.period - 1'b1);

  always_comb begin
    active_d  = active_q;
    reload_d  = reload_q;
    count_d   = count_q;
    tick_en_d = tick_en_q;
    fire      = '0;
    bad       = 1'b0;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (tick_en_q) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (active_q[i]) begin
              if (count_q[i] >= reload_q[i]) begin
                fire[i]    = 1'b1;
                count_d[i] = '0;
              end else begin
                count_d[i] = PERIOD_W'(count_q[i] + 1'b1);
              end
            end
          end
          if (active_q == '0) tick_en_d = 1'b0;
        end
      end
      ACT_ARM: begin
        if (!in_range) begin
          bad = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (hit[i]) begin
              active_d[i] = 1'b1;
              reload_d[i] = new_reload;
              count_d[i]  = '0;
            end
          end
          // start the tick source only when this is the sole active slot
          if ((active_q & ~hit) == '0) tick_en_d = 1'b1;
        end
      end
      ACT_DISARM: begin
        if (!in_range) begin
          bad = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (hit[i]) begin
              active_d[i] = 1'b0;
              reload_d[i] = '0;
              count_d[i]  = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // slots past the mask width have no bit
  for (genvar j = 0; j < MASK_W; j++) begin : g_mask
    if (j < SLOTS) begin : g_on
      assign fire_mask[j] = fire[j];
    end else begin : g_off
      assign fire_mask[j] = 1'b0;
    end
  end

  assign res_o = '{fire_mask: fire_mask, running: tick_en_d, bad_slot: bad};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      tick_en_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        reload_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else if (en_i) begin
      active_q  <= active_d;
      tick_en_q <= tick_en_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/msts_checker.sv =====
// ----------------------------------------------------------------------------
// msts_checker
// Port-level checks of the tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_slot_periodic_tick_scheduler_macros.svh"

module msts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] fire_mask_i,
  input wire logic       running_i,
  input wire logic       bad_slot_i
);

  // a stalled result beat holds
  `MSTS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(fire_mask_i) && $stable(running_i) && $stable(bad_slot_i), "result beat changed while stalled")

  // a slot can only fire while some slot keeps the tick source on
  `MSTS_ASSERT(a_fire_running, out_valid_i && (fire_mask_i != 8'd0), running_i, "fire without running")

  // a rejected command never fires anything
  `MSTS_ASSERT(a_bad_no_fire, out_valid_i && bad_slot_i, fire_mask_i == 8'd0, "fire on bad slot beat")

  // an idle result side wakes only once an accepted beat has passed the input register
  `MSTS_ASSERT(a_latency, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without command")

endmodule

bind multi_slot_periodic_tick_scheduler msts_checker u_msts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .fire_mask_i(out_o.fire_mask),
  .running_i  (out_o.running),
  .bad_slot_i (out_o.bad_slot)
);

`default_nettype wire

// ===== verif/msts_sched_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msts_sched_checker
// Watches both channels of the tick scheduler, keeps its own copy of the slot
// bank, predicts one result beat per command beat, compares in order.
// ----------------------------------------------------------------------------
module msts_sched_checker
  import msts_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  msts_in_if   cmd_i,
  msts_out_if  res_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);

  logic                slot_armed  [SLOTS];
  logic [PERIOD_W-1:0] slot_reload [SLOTS];
  logic [PERIOD_W-1:0] slot_count  [SLOTS];
  logic                tick_on;
  out_beat_t           due_beats[$];
  out_beat_t           want;

  // Applies one command to the slot bank copy, returns the beat it yields.
  function automatic out_beat_t advance_slots(input logic [ACT_W-1:0]    act,
                                              input logic [SLOT_W-1:0]   sl,
                                              input logic [PERIOD_W-1:0] per);
    out_beat_t res;
    logic      any_armed;
    res       = '0;
    any_armed = 1'b0;
    case (act)
      ACT_TICK: begin
        if (tick_on) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_armed[i]) begin
              any_armed = 1'b1;
              if (slot_count[i] >= slot_reload[i]) begin
                if (i < MASK_W) res.fire_mask[i] = 1'b1;
                slot_count[i] = '0;
              end else begin
                slot_count[i] = slot_count[i] + 1'b1;
              end
            end
          end
          // a tick with nothing armed shuts the tick source off
          if (!any_armed) tick_on = 1'b0;
        end
      end
      ACT_ARM, ACT_DISARM: begin
        if (sl >= SLOTS) begin
          res.bad_slot = 1'b1;
        end else if (act == ACT_ARM) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (i != sl && slot_armed[i]) any_armed = 1'b1;
          end
          slot_armed[sl]  = 1'b1;
          slot_reload[sl] = (per == '0) ? '0 : per - 1'b1;
          slot_count[sl]  = '0;
          if (!any_armed) tick_on = 1'b1;
        end else begin
          slot_armed[sl]  = 1'b0;
          slot_reload[sl] = '0;
          slot_count[sl]  = '0;
        end
      end
      default: ;
    endcase
    res.running = tick_on;
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_armed[i]  = 1'b0;
        slot_reload[i] = '0;
        slot_count[i]  = '0;
      end
      tick_on = 1'b0;
      due_beats.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (due_beats.size() == 0) begin
          note_mismatch($sformatf("result beat with none pending (mask %h)",
                                  res_i.fire_mask));
        end else begin
          want = due_beats.pop_front();
          if (res_i.fire_mask !== want.fire_mask)
            note_mismatch($sformatf("fire_mask %h, want %h", res_i.fire_mask,
                                    want.fire_mask));
          if (res_i.running !== want.running)
            note_mismatch($sformatf("running %b, want %b", res_i.running,
                                    want.running));
          if (res_i.bad_slot !== want.bad_slot)
            note_mismatch($sformatf("bad_slot %b, want %b", res_i.bad_slot,
                                    want.bad_slot));
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        due_beats.push_back(advance_slots(cmd_i.action, cmd_i.slot, cmd_i.period));
      pending_cnt_o <= due_beats.size();
    end
  end

endmodule

// ===== verif/tb_multi_slot_periodic_tick_scheduler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_slot_periodic_tick_scheduler
// Drives tick, arm, disarm and spare command beats with random gaps and
// result stalls, a long result hold-off and a full drain; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_multi_slot_periodic_tick_scheduler;
  import msts_pkg::*;

  localparam int unsigned      SLOTS        = 8;
  localparam logic [ACT_W-1:0] ACT_SPARE    = 2'd3;
  localparam int               RANDOM_BEATS = 450;
  localparam int               HOLD_AT      = 150;
  localparam int               PAUSE_AT     = 300;
  localparam int               TAIL_FROM    = RANDOM_BEATS - 80;
  localparam int               HOLD_CYCLES  = 80;
  localparam int               DRAIN_LIMIT  = 5000;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;
  logic quiet_tail = 1'b0;
  int   mismatch_cnt;
  int   pending_cnt;

  msts_in_if  cmd_if ();
  msts_out_if res_if ();

  multi_slot_periodic_tick_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  msts_sched_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_cmd(input logic [ACT_W-1:0]    act,
                          input logic [SLOT_W-1:0]   sl,
                          input logic [PERIOD_W-1:0] per);
    cmd_if.valid  <= 1'b1;
    cmd_if.action <= act;
    cmd_if.slot   <= sl;
    cmd_if.period <= per;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic idle_cmd(input int cycles);
    cmd_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Mostly ticks and small periods so slots fire often; some wide periods
  // and out-of-range slots for field coverage.
  task automatic send_random_cmd();
    int unsigned         pick;
    logic [ACT_W-1:0]    act;
    logic [SLOT_W-1:0]   sl;
    logic [PERIOD_W-1:0] per;
    pick = $urandom_range(0, 99);
    if (pick < 50)      act = ACT_TICK;
    else if (pick < 76) act = ACT_ARM;
    else if (pick < 96) act = ACT_DISARM;
    else                act = ACT_SPARE;
    if ($urandom_range(0, 9) == 0) sl = SLOT_W'($urandom_range(8, 15));
    else                           sl = SLOT_W'($urandom_range(0, SLOTS - 1));
    if ($urandom_range(0, 3) == 0) per = PERIOD_W'($urandom);
    else                           per = PERIOD_W'($urandom_range(0, 6));
    send_cmd(act, sl, per);
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(0, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int w;
    cmd_if.valid  <= 1'b0;
    cmd_if.action <= ACT_TICK;
    cmd_if.slot   <= '0;
    cmd_if.period <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(ACT_TICK, 4'd0, 16'd0);          // tick while stopped
    send_cmd(ACT_ARM, 4'd0, 16'd0);           // period zero fires every tick
    send_cmd(ACT_TICK, 4'd0, 16'd0);
    send_cmd(ACT_TICK, 4'd0, 16'd0);
    send_cmd(ACT_ARM, 4'd1, 16'd1);
    send_cmd(ACT_ARM, 4'd2, 16'd3);
    send_cmd(ACT_ARM, 4'd3, 16'd2);
    send_cmd(ACT_ARM, 4'd7, 16'hFFFF);
    repeat (3) send_cmd(ACT_TICK, 4'hF, 16'hFFFF);
    send_cmd(ACT_ARM, 4'd2, 16'd2);           // re-arm while active
    send_cmd(ACT_ARM, 4'd8, 16'hFFFF);        // slot out of range
    send_cmd(ACT_DISARM, 4'hF, 16'd0);
    send_cmd(ACT_SPARE, 4'hF, 16'hFFFF);
    send_cmd(ACT_DISARM, 4'd0, 16'd0);
    send_cmd(ACT_DISARM, 4'd1, 16'd0);
    send_cmd(ACT_DISARM, 4'd2, 16'd0);
    send_cmd(ACT_DISARM, 4'd3, 16'd0);
    send_cmd(ACT_DISARM, 4'd7, 16'd0);        // last slot: still running
    send_cmd(ACT_TICK, 4'd0, 16'd0);          // finds nothing armed, stops
    send_cmd(ACT_TICK, 4'd0, 16'd0);
    send_cmd(ACT_DISARM, 4'd5, 16'd0);        // disarm of an idle slot
    send_cmd(ACT_ARM, 4'd6, 16'h8000);
    send_cmd(ACT_TICK, 4'd0, 16'd0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == TAIL_FROM) quiet_tail = 1'b1;
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        idle_cmd(1);
        while (pending_cnt != 0) @(posedge clk_i);
      end else if (!quiet_tail && !(hold_req && !hold_done) &&
                   $urandom_range(0, 4) == 0) begin
        idle_cmd($urandom_range(1, 14));
      end
      send_random_cmd();
    end

    idle_cmd(1);
    for (w = 0; w < DRAIN_LIMIT && pending_cnt != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/msts_pkg.sv
src/msts_if.sv
src/msts_slot_bank.sv
src/multi_slot_periodic_tick_scheduler.sv
src/msts_checker.sv
verif/msts_sched_checker.sv
verif/tb_multi_slot_periodic_tick_scheduler.sv
